// File: rtl/alst_pkg.sv
// Shared constants, codes and payload types for the array-backed linked list.
`timescale 1ns / 1ps

package alst_pkg;

  // Number of slots in the list; slot, position and count widths follow from it.
  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LINK_W   = $clog2(CAPACITY + 2);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 64;

  // Link word codes beyond the slot indices.
  localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(CAPACITY);
  localparam logic [LINK_W-1:0] LINK_FREE = LINK_W'(CAPACITY + 1);

  typedef enum logic [2:0] {
    KIND_ADD_FIRST = 3'd0,
    KIND_ADD_AFTER = 3'd1,
    KIND_ADD_LAST  = 3'd2,
    KIND_DEL_FIRST = 3'd3,
    KIND_DEL_AFTER = 3'd4,
    KIND_DEL_LAST  = 3'd5,
    KIND_CLEAR     = 3'd6,
    KIND_WALK      = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_NOPOS  = 3'd3,
    STAT_NOSUCC = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_EXEC  = 3'd1,
    S_TAIL  = 3'd2,
    S_DEL2  = 3'd3,
    S_DLAST = 3'd4,
    S_WALK  = 3'd5
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   position;
    logic [WORD_W-1:0]   record_key;
    logic [WORD_W-1:0]   record_name;
    logic [WORD_W-1:0]   record_value;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [CNT_W-1:0]    element_count;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   out_key;
    logic [WORD_W-1:0]   out_name;
    logic [WORD_W-1:0]   out_value;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [WORD_W-1:0]   key;
    logic [WORD_W-1:0]   name;
    logic [WORD_W-1:0]   value;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Two write ports and a clear for the link store.
  typedef struct packed {
    logic                clear;
    logic                we0;
    logic [SLOT_W-1:0]   wa0;
    logic [LINK_W-1:0]   wd0;
    logic                we1;
    logic [SLOT_W-1:0]   wa1;
    logic [LINK_W-1:0]   wd1;
  } link_wr_t;

endpackage

// File: rtl/alst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module alst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/alst_links.sv
// Link store: one link word per slot, one read port, two write ports, lowest free slot.
`timescale 1ns / 1ps

module alst_links (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [alst_pkg::SLOT_W-1:0]   rd_addr,
  output logic [alst_pkg::LINK_W-1:0]   rd_data,
  input  alst_pkg::link_wr_t            wr,
  output logic [alst_pkg::SLOT_W-1:0]   lowest_free
);

  logic [alst_pkg::LINK_W-1:0] link_r [alst_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      for (int i = 0; i < alst_pkg::CAPACITY; i++) begin
        link_r[i] <= alst_pkg::LINK_FREE;
      end
    end else begin
      if (wr.we0) begin
        link_r[wr.wa0] <= wr.wd0;
      end
      if (wr.we1) begin
        link_r[wr.wa1] <= wr.wd1;
      end
    end
  end

  assign rd_data = link_r[rd_addr];

  // Priority encoder: scanning downwards leaves the lowest free slot.
  always_comb begin
    lowest_free = '0;
    for (int i = alst_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (link_r[i] == alst_pkg::LINK_FREE) begin
        lowest_free = alst_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

// File: rtl/array_linked_list.sv
// Top level of the array-backed singly linked list with command-style handshake.
// Head, clear and error commands give their result from the execute state.
// Delete-after adds the S_DEL2 step; append and delete-tail walk the list element by element.
// A walk of n elements gives one result per cycle, n results in all.
// The link-following loop, one link read per cycle, sets the rate of append, delete-tail and walk.
// Reset frees every slot, empties the list and clears the count; records are not cleared.
`timescale 1ns / 1ps

module array_linked_list (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  alst_pkg::cmd_t  in_cmd,
  output logic            busy,
  output logic            out_valid,
  output alst_pkg::res_t  out_res
);

  alst_pkg::state_t             state_r, state_nxt;
  alst_pkg::kind_t              kind_r;
  logic [alst_pkg::SLOT_W-1:0]  pos_r;
  alst_pkg::rec_t               rec_r;
  logic [alst_pkg::LINK_W-1:0]  head_r, head_nxt;
  logic [alst_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [alst_pkg::SLOT_W-1:0]  cur_r, cur_nxt;
  logic [alst_pkg::LINK_W-1:0]  prev_r, prev_nxt;

  logic                         out_valid_r, out_valid_nxt;
  alst_pkg::status_t            out_status_r, out_status_nxt;
  logic [alst_pkg::SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_walk_r, out_walk_nxt;

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [alst_pkg::SLOT_W-1:0]  rd_addr;
  logic [alst_pkg::LINK_W-1:0]  rd_data;
  logic                         rd_end;
  logic                         rd_free;
  logic [alst_pkg::SLOT_W-1:0]  lowest_free;
  alst_pkg::link_wr_t           lw;
  logic                         ram_we;
  alst_pkg::rec_t               ram_rdata;

  assign accept  = start && (state_r == alst_pkg::S_IDLE);
  assign busy    = (state_r != alst_pkg::S_IDLE);
  assign full    = (count_r == alst_pkg::CNT_W'(alst_pkg::CAPACITY));
  assign empty   = (head_r == alst_pkg::LINK_END);
  assign rd_free = (rd_data == alst_pkg::LINK_FREE);
  assign rd_end  = (rd_data >= alst_pkg::LINK_END);

  alst_links u_links (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr          (lw),
    .lowest_free (lowest_free)
  );

  alst_ram #(
    .WIDTH (alst_pkg::REC_W),
    .DEPTH (alst_pkg::CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lowest_free),
    .wdata (rec_r),
    .raddr (cur_r),
    .rdata (ram_rdata)
  );

  // The single link read port follows the sequencer.
  always_comb begin
    case (state_r)
      alst_pkg::S_EXEC: begin
        rd_addr = (kind_r == alst_pkg::KIND_DEL_FIRST) ? head_r[alst_pkg::SLOT_W-1:0] : pos_r;
      end
      default: begin
        rd_addr = cur_r;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alst_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = alst_pkg::S_EXEC;
        end
      end
      alst_pkg::S_EXEC: begin
        state_nxt = alst_pkg::S_IDLE;
        case (kind_r)
          alst_pkg::KIND_ADD_LAST: begin
            if (!full) begin
              state_nxt = alst_pkg::S_TAIL;
            end
          end
          alst_pkg::KIND_DEL_AFTER: begin
            if (!rd_free && !rd_end) begin
              state_nxt = alst_pkg::S_DEL2;
            end
          end
          alst_pkg::KIND_DEL_LAST: begin
            if (!empty) begin
              state_nxt = alst_pkg::S_DLAST;
            end
          end
          alst_pkg::KIND_WALK: begin
            if (!empty) begin
              state_nxt = alst_pkg::S_WALK;
            end
          end
          default: begin
            state_nxt = alst_pkg::S_IDLE;
          end
        endcase
      end
      alst_pkg::S_DEL2: begin
        state_nxt = alst_pkg::S_IDLE;
      end
      alst_pkg::S_TAIL, alst_pkg::S_DLAST, alst_pkg::S_WALK: begin
        if (rd_end) begin
          state_nxt = alst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = alst_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, link writes and result.
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    lw             = '0;
    ram_we         = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = alst_pkg::STAT_OK;
    out_slot_nxt   = '0;
    out_last_nxt   = 1'b1;
    out_walk_nxt   = 1'b0;
    case (state_r)
      alst_pkg::S_EXEC: begin
        out_valid_nxt = 1'b1;
        case (kind_r)
          alst_pkg::KIND_ADD_FIRST: begin
            if (full) begin
              out_status_nxt = alst_pkg::STAT_FULL;
            end else begin
              ram_we       = 1'b1;
              lw.we0       = 1'b1;
              lw.wa0       = lowest_free;
              lw.wd0       = head_r;
              head_nxt     = alst_pkg::LINK_W'(lowest_free);
              count_nxt    = count_r + alst_pkg::CNT_W'(1);
              out_slot_nxt = lowest_free;
            end
          end
          alst_pkg::KIND_ADD_AFTER: begin
            if (full) begin
              out_status_nxt = alst_pkg::STAT_FULL;
            end else if (rd_free) begin
              out_status_nxt = alst_pkg::STAT_NOPOS;
            end else begin
              ram_we       = 1'b1;
              lw.we0       = 1'b1;
              lw.wa0       = lowest_free;
              lw.wd0       = rd_data;
              lw.we1       = 1'b1;
              lw.wa1       = pos_r;
              lw.wd1       = alst_pkg::LINK_W'(lowest_free);
              count_nxt    = count_r + alst_pkg::CNT_W'(1);
              out_slot_nxt = lowest_free;
            end
          end
          alst_pkg::KIND_ADD_LAST: begin
            if (full) begin
              out_status_nxt = alst_pkg::STAT_FULL;
            end else begin
              out_valid_nxt = 1'b0;
              cur_nxt       = head_r[alst_pkg::SLOT_W-1:0];
            end
          end
          alst_pkg::KIND_DEL_FIRST: begin
            if (empty) begin
              out_status_nxt = alst_pkg::STAT_EMPTY;
            end else begin
              head_nxt     = rd_data;
              lw.we0       = 1'b1;
              lw.wa0       = head_r[alst_pkg::SLOT_W-1:0];
              lw.wd0       = alst_pkg::LINK_FREE;
              count_nxt    = count_r - alst_pkg::CNT_W'(1);
              out_slot_nxt = head_r[alst_pkg::SLOT_W-1:0];
            end
          end
          alst_pkg::KIND_DEL_AFTER: begin
            if (rd_free) begin
              out_status_nxt = alst_pkg::STAT_NOPOS;
            end else if (rd_end) begin
              out_status_nxt = alst_pkg::STAT_NOSUCC;
            end else begin
              out_valid_nxt = 1'b0;
              cur_nxt       = rd_data[alst_pkg::SLOT_W-1:0];
            end
          end
          alst_pkg::KIND_DEL_LAST: begin
            if (empty) begin
              out_status_nxt = alst_pkg::STAT_EMPTY;
            end else begin
              out_valid_nxt = 1'b0;
              cur_nxt       = head_r[alst_pkg::SLOT_W-1:0];
              prev_nxt      = alst_pkg::LINK_END;
            end
          end
          alst_pkg::KIND_CLEAR: begin
            lw.clear  = 1'b1;
            head_nxt  = alst_pkg::LINK_END;
            count_nxt = '0;
          end
          alst_pkg::KIND_WALK: begin
            if (empty) begin
              out_status_nxt = alst_pkg::STAT_EMPTY;
            end else begin
              out_valid_nxt = 1'b0;
              cur_nxt       = head_r[alst_pkg::SLOT_W-1:0];
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      alst_pkg::S_TAIL: begin
        if (rd_end) begin
          // The tail is found: the new slot becomes the end of the list.
          ram_we        = 1'b1;
          lw.we0        = 1'b1;
          lw.wa0        = lowest_free;
          lw.wd0        = alst_pkg::LINK_END;
          lw.we1        = 1'b1;
          lw.wa1        = cur_r;
          lw.wd1        = alst_pkg::LINK_W'(lowest_free);
          count_nxt     = count_r + alst_pkg::CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_slot_nxt  = lowest_free;
        end else begin
          cur_nxt = rd_data[alst_pkg::SLOT_W-1:0];
        end
      end
      alst_pkg::S_DEL2: begin
        lw.we0        = 1'b1;
        lw.wa0        = pos_r;
        lw.wd0        = rd_data;
        lw.we1        = 1'b1;
        lw.wa1        = cur_r;
        lw.wd1        = alst_pkg::LINK_FREE;
        count_nxt     = count_r - alst_pkg::CNT_W'(1);
        out_valid_nxt = 1'b1;
        out_slot_nxt  = cur_r;
      end
      alst_pkg::S_DLAST: begin
        if (rd_end) begin
          // A tail with no predecessor is the head, so the list becomes empty.
          if (prev_r == alst_pkg::LINK_END) begin
            head_nxt = alst_pkg::LINK_END;
          end else begin
            lw.we0 = 1'b1;
            lw.wa0 = prev_r[alst_pkg::SLOT_W-1:0];
            lw.wd0 = alst_pkg::LINK_END;
          end
          lw.we1        = 1'b1;
          lw.wa1        = cur_r;
          lw.wd1        = alst_pkg::LINK_FREE;
          count_nxt     = count_r - alst_pkg::CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_slot_nxt  = cur_r;
        end else begin
          prev_nxt = alst_pkg::LINK_W'(cur_r);
          cur_nxt  = rd_data[alst_pkg::SLOT_W-1:0];
        end
      end
      alst_pkg::S_WALK: begin
        // The record read issued now lines up with the result register next cycle.
        out_valid_nxt = 1'b1;
        out_slot_nxt  = cur_r;
        out_walk_nxt  = 1'b1;
        out_last_nxt  = rd_end;
        if (!rd_end) begin
          cur_nxt = rd_data[alst_pkg::SLOT_W-1:0];
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alst_pkg::S_IDLE;
      head_r      <= alst_pkg::LINK_END;
      count_r     <= '0;
      cur_r       <= '0;
      prev_r      <= alst_pkg::LINK_END;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
    out_walk_r   <= out_walk_nxt;
    if (accept) begin
      // Appending to an empty list is the same as inserting at the head.
      if (in_cmd.kind == alst_pkg::KIND_ADD_LAST && empty) begin
        kind_r <= alst_pkg::KIND_ADD_FIRST;
      end else begin
        kind_r <= in_cmd.kind;
      end
      pos_r       <= in_cmd.position;
      rec_r.key   <= in_cmd.record_key;
      rec_r.name  <= in_cmd.record_name;
      rec_r.value <= in_cmd.record_value;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_res.status        = out_status_r;
    out_res.element_count = count_r;
    out_res.slot          = out_slot_r;
    out_res.out_key       = out_walk_r ? ram_rdata.key   : '0;
    out_res.out_name      = out_walk_r ? ram_rdata.name  : '0;
    out_res.out_value     = out_walk_r ? ram_rdata.value : '0;
    out_res.last          = out_last_r;
  end

`ifndef SYNTHESIS
  // A transfer that is not the last of its command must find the block still busy.
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last |-> busy)
    else $error("non-final result while the block is idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= alst_pkg::CNT_W'(alst_pkg::CAPACITY))
    else $error("element count exceeds capacity");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == alst_pkg::LINK_END) == (count_r == '0))
    else $error("head pointer and element count disagree");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("command accepted but sequencer did not start");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_walk_r |-> out_res.last)
    else $error("non-walk command gave more than one result");
`endif

endmodule
